/* rtl/dcmf_pkg.sv */
// ----------------------------------------------------------------------------
// dcmf_pkg
// Shared types and constants of the depth crop / mirror filter.
// ----------------------------------------------------------------------------
package dcmf_pkg;

    localparam int MAX_DIM  = 1024;
    localparam int DEPTH_W  = 16;
    localparam int COORD_W  = 10;   // column / row position
    localparam int SIZE_W   = 11;   // sizes up to MAX_DIM
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH   = 3'd0,
        REG_CROP_ENABLE   = 3'd1,
        REG_CROP_LEFT     = 3'd2,
        REG_CROP_TOP      = 3'd3,
        REG_CROP_WIDTH    = 3'd4,
        REG_CROP_HEIGHT   = 3'd5,
        REG_MIRROR_ENABLE = 3'd6,
        REG_MAX_DEPTH     = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [SIZE_W-1:0]  frame_width;
        logic               crop_enable;
        logic [COORD_W-1:0] crop_left;
        logic [COORD_W-1:0] crop_top;
        logic [SIZE_W-1:0]  crop_width;
        logic [SIZE_W-1:0]  crop_height;
        logic               mirror_enable;
        logic [DEPTH_W-1:0] max_depth;
    } cfg_t;

    // pixel with its position in the sensor frame
    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } pix_t;

endpackage

/* rtl/dcmf_cfg_regs.sv */
// ----------------------------------------------------------------------------
// dcmf_cfg_regs
// Configuration register file, written through a valid/ready channel.
// ----------------------------------------------------------------------------
module dcmf_cfg_regs
    import dcmf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (reg_idx_t'(cfg_index))
                REG_FRAME_WIDTH:   cfg_next.frame_width   = cfg_data[SIZE_W-1:0];
                REG_CROP_ENABLE:   cfg_next.crop_enable   = cfg_data[0];
                REG_CROP_LEFT:     cfg_next.crop_left     = cfg_data[COORD_W-1:0];
                REG_CROP_TOP:      cfg_next.crop_top      = cfg_data[COORD_W-1:0];
                REG_CROP_WIDTH:    cfg_next.crop_width    = cfg_data[SIZE_W-1:0];
                REG_CROP_HEIGHT:   cfg_next.crop_height   = cfg_data[SIZE_W-1:0];
                REG_MIRROR_ENABLE: cfg_next.mirror_enable = cfg_data[0];
                REG_MAX_DEPTH:     cfg_next.max_depth     = cfg_data[DEPTH_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_width   <= SIZE_W'(640);
            cfg_reg.crop_enable   <= 1'b0;
            cfg_reg.crop_left     <= '0;
            cfg_reg.crop_top      <= '0;
            cfg_reg.crop_width    <= SIZE_W'(640);
            cfg_reg.crop_height   <= SIZE_W'(480);
            cfg_reg.mirror_enable <= 1'b0;
            cfg_reg.max_depth     <= DEPTH_W'(10000);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/dcmf_pos_track.sv */
// ----------------------------------------------------------------------------
// dcmf_pos_track
// Column/row counters and the input register: tags each pixel with its
// position in the sensor frame.
// ----------------------------------------------------------------------------
module dcmf_pos_track
    import dcmf_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [DEPTH_W-1:0] s_depth_in,
    input  logic               s_frame_start,
    output logic               pix_valid,
    input  logic               pix_ready,
    output pix_t               pix
);

    logic [COORD_W-1:0] col_count_reg, col_count_next;
    logic [COORD_W-1:0] row_count_reg, row_count_next;
    logic               valid_reg, valid_next;
    pix_t               pix_reg;

    logic [SIZE_W-1:0]  fwidth;
    logic [COORD_W-1:0] col, row;
    logic [SIZE_W-1:0]  col_inc;
    logic               accept;

    // width 0 acts as 1, anything above MAX_DIM as MAX_DIM
    always_comb begin
        if (cfg.frame_width == '0)
            fwidth = SIZE_W'(1);
        else if (cfg.frame_width > SIZE_W'(MAX_DIM))
            fwidth = SIZE_W'(MAX_DIM);
        else
            fwidth = cfg.frame_width;
    end

    assign s_ready = !valid_reg || pix_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        if (s_frame_start) begin
            col = '0;
            row = '0;
        end else begin
            col = ({1'b0, col_count_reg} >= fwidth) ? '0 : col_count_reg;
            row = row_count_reg;
        end
        col_inc = {1'b0, col} + SIZE_W'(1);

        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (accept) begin
            if (col_inc >= fwidth) begin
                col_count_next = '0;
                row_count_next = row + COORD_W'(1);  // wraps at MAX_DIM
            end else begin
                col_count_next = col_inc[COORD_W-1:0];
                row_count_next = row;
            end
        end

        valid_next = accept || (valid_reg && !pix_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            valid_reg     <= 1'b0;
        end else begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            valid_reg     <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pix_reg.depth <= s_depth_in;
            pix_reg.col   <= col;
            pix_reg.row   <= row;
        end
    end

    assign pix_valid = valid_reg;
    assign pix       = pix_reg;

endmodule

/* rtl/dcmf_window.sv */
// ----------------------------------------------------------------------------
// dcmf_window
// Crop test, mirroring and depth limit, followed by the result register.
// ----------------------------------------------------------------------------
module dcmf_window
    import dcmf_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  logic               pix_valid,
    output logic               pix_ready,
    input  pix_t               pix,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [DEPTH_W-1:0] m_depth_out,
    output logic [COORD_W-1:0] m_out_col,
    output logic [COORD_W-1:0] m_out_row,
    output logic               m_window_last
);

    logic               valid_reg, valid_next;
    logic [DEPTH_W-1:0] depth_reg;
    logic [COORD_W-1:0] col_reg, row_reg;
    logic               last_reg;

    logic [SIZE_W-1:0]  fwidth_m1;
    logic [COORD_W-1:0] rel_col, rel_row;
    logic               keep;
    logic               last;
    logic [COORD_W-1:0] ocol, orow;
    logic [DEPTH_W-1:0] depth;
    logic               load;

    always_comb begin
        // frame width clamp, minus one
        if (cfg.frame_width == '0)
            fwidth_m1 = '0;
        else if (cfg.frame_width > SIZE_W'(MAX_DIM))
            fwidth_m1 = SIZE_W'(MAX_DIM - 1);
        else
            fwidth_m1 = cfg.frame_width - SIZE_W'(1);

        rel_col = pix.col - cfg.crop_left;
        rel_row = pix.row - cfg.crop_top;
        keep    = 1'b1;
        last    = 1'b0;

        if (cfg.crop_enable) begin
            if (pix.col < cfg.crop_left || {1'b0, rel_col} >= cfg.crop_width ||
                pix.row < cfg.crop_top  || {1'b0, rel_row} >= cfg.crop_height)
                keep = 1'b0;
            last = ({1'b0, rel_col} == cfg.crop_width - SIZE_W'(1)) &&
                   ({1'b0, rel_row} == cfg.crop_height - SIZE_W'(1));
            orow = rel_row;
            if (cfg.mirror_enable)
                ocol = cfg.crop_width[COORD_W-1:0] - COORD_W'(1) - rel_col;
            else
                ocol = rel_col;
        end else begin
            orow = pix.row;
            if (cfg.mirror_enable)
                ocol = fwidth_m1[COORD_W-1:0] - pix.col;
            else
                ocol = pix.col;
        end

        depth = (pix.depth < cfg.max_depth) ? pix.depth : '0;
    end

    assign pix_ready  = !valid_reg || m_ready;
    assign load       = pix_valid && pix_ready && keep;
    // dropped pixels are consumed without producing a transfer
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            depth_reg <= depth;
            col_reg   <= ocol;
            row_reg   <= orow;
            last_reg  <= last && cfg.crop_enable;
        end
    end

    assign m_valid       = valid_reg;
    assign m_depth_out   = depth_reg;
    assign m_out_col     = col_reg;
    assign m_out_row     = row_reg;
    assign m_window_last = last_reg;

endmodule

/* rtl/depth_crop_mirror_filter.sv */
// ----------------------------------------------------------------------------
// depth_crop_mirror_filter
// Crops, mirrors and range-limits a raster stream of 16-bit depth pixels.
// ----------------------------------------------------------------------------
// Takes one pixel per cycle on s_ while s_ready is high, returns kept pixels
// on m_: one register stage tags the pixel with its column/row from the frame
// counters, the second applies the crop window, mirroring and the max_depth
// limit into the result register. Pixels outside the window produce no output
// transfer. Each stage has its own valid, so a new pixel is taken while a
// result waits on m_ready only if the first stage is empty. s_frame_start
// marks column 0, row 0. Registers are written on the cfg_ channel (always
// ready) and should be changed only while no pixel is in flight.
module depth_crop_mirror_filter
    import dcmf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [DEPTH_W-1:0]    s_depth_in,
    input  logic                  s_frame_start,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [DEPTH_W-1:0]    m_depth_out,
    output logic [COORD_W-1:0]    m_out_col,
    output logic [COORD_W-1:0]    m_out_row,
    output logic                  m_window_last
);

    cfg_t cfg;
    logic pix_valid;
    logic pix_ready;
    pix_t pix;

    dcmf_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dcmf_pos_track u_pos (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_depth_in    (s_depth_in),
        .s_frame_start (s_frame_start),
        .pix_valid     (pix_valid),
        .pix_ready     (pix_ready),
        .pix           (pix)
    );

    dcmf_window u_win (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .pix_valid     (pix_valid),
        .pix_ready     (pix_ready),
        .pix           (pix),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_depth_out   (m_depth_out),
        .m_out_col     (m_out_col),
        .m_out_row     (m_out_row),
        .m_window_last (m_window_last)
    );

endmodule
